// ===== design/ttp_pkg.sv =====
// ttp_pkg: widths, constants and the divider cell payload for the triangle tangent packer
// no dependencies; used by the channel interfaces and every module of the block
`default_nettype none

package ttp_pkg;

   localparam int UV_CODE_BITS      = 14;
   localparam int TANGENT_CODE_BITS = 10;
   localparam int FRAC_BITS         = TANGENT_CODE_BITS - 1;
   localparam int CODE_MAX          = (1 << FRAC_BITS) - 1;
   localparam int CODE_HALF         = 1 << (FRAC_BITS - 1);
   // floor(11/20 * 2^frac), z of the default tangent
   localparam int CODE_Z_DEFAULT    = (11 * (1 << FRAC_BITS)) / 20;

   localparam int POS_W        = 32;
   localparam int UV_W         = 30;
   localparam int V_LSB        = 16;
   localparam int OUT_W        = 30;
   localparam int FIELD_STRIDE = 10;

   localparam int DP_W   = POS_W + 1;
   localparam int DIFF_W = UV_CODE_BITS + 1;
   localparam int PROD_W = DP_W + DIFF_W;
   localparam int N_W    = PROD_W + 1;
   localparam int DET_W  = 2 * UV_CODE_BITS + 2;
   localparam int MAG_W  = DET_W - 1;
   // scale 13107200 = 25 * 2^19
   localparam int M_SHIFT = 19;
   localparam int M_W     = MAG_W + 5 + M_SHIFT;
   localparam int DEN_W   = M_W + 1;
   localparam int S_W     = N_W + UV_CODE_BITS;
   localparam int CMP_W   = ((S_W > DEN_W) ? S_W : DEN_W) + 1;

   // |d| > 1e-6 is |D| * 4e8 > 2^(2*uv bits)
   localparam longint DEGEN_LIMIT = (longint'(1) << (2 * UV_CODE_BITS)) / 64'd400000000;

   localparam logic [OUT_W-1:0] DEFAULT_WORD = {
      FIELD_STRIDE'(CODE_Z_DEFAULT), FIELD_STRIDE'(CODE_HALF), FIELD_STRIDE'(CODE_HALF)};

   typedef struct packed {
      logic [2:0][DEN_W-1:0]     rem;
      logic [2:0][FRAC_BITS-1:0] quo;
      logic [DEN_W-1:0]          den;
      logic [2:0]                sat_hi;
      logic [2:0]                sat_lo;
      logic                      degen;
   } cell_data_type;

endpackage

`default_nettype wire

// ===== design/ttp_channels.sv =====
// ttp_req_if / ttp_rsp_if: valid-ready channels carrying one triangle and one packed tangent
// depends on ttp_pkg
`default_nettype none

interface ttp_req_if;
   logic valid;
   logic ready;
   logic signed [ttp_pkg::POS_W-1:0] p0_x, p0_y, p0_z;
   logic signed [ttp_pkg::POS_W-1:0] p1_x, p1_y, p1_z;
   logic signed [ttp_pkg::POS_W-1:0] p2_x, p2_y, p2_z;
   logic [ttp_pkg::UV_W-1:0] uv_word_0, uv_word_1, uv_word_2;

   modport source (output valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
                   uv_word_0, uv_word_1, uv_word_2, input ready);
   modport sink (input valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
                 uv_word_0, uv_word_1, uv_word_2, output ready);
endinterface

interface ttp_rsp_if;
   logic valid;
   logic ready;
   logic [ttp_pkg::OUT_W-1:0] tangent_word;
   logic degenerate;

   modport source (output valid, tangent_word, degenerate, input ready);
   modport sink (input valid, tangent_word, degenerate, output ready);
endinterface

`default_nettype wire

// ===== design/ttp_front.sv =====
// ttp_front: five-stage front end: deltas, products, determinant, sign fold, scaled compare
// depends on ttp_pkg and ttp_req_if; feeds the first divider cell
`default_nettype none

module ttp_front (
   input  wire logic           clock,
   input  wire logic           reset,
   ttp_req_if.sink             req_chan,
   output logic                out_valid,
   output ttp_pkg::cell_data_type out_data,
   input  wire logic           out_ready
);

   localparam int DP_W   = ttp_pkg::DP_W;
   localparam int DIFF_W = ttp_pkg::DIFF_W;
   localparam int PROD_W = ttp_pkg::PROD_W;
   localparam int N_W    = ttp_pkg::N_W;
   localparam int DET_W  = ttp_pkg::DET_W;
   localparam int MAG_W  = ttp_pkg::MAG_W;
   localparam int M_W    = ttp_pkg::M_W;
   localparam int DEN_W  = ttp_pkg::DEN_W;
   localparam int S_W    = ttp_pkg::S_W;
   localparam int CMP_W  = ttp_pkg::CMP_W;
   localparam int UVB    = ttp_pkg::UV_CODE_BITS;

   logic [4:0] v_ff, v_in, take;

   logic signed [DP_W-1:0]   s1_dp1_ff [3], s1_dp1_in [3];
   logic signed [DP_W-1:0]   s1_dp2_ff [3], s1_dp2_in [3];
   logic signed [DIFF_W-1:0] s1_a1_ff, s1_a2_ff, s1_b1_ff, s1_b2_ff;
   logic signed [DIFF_W-1:0] s1_a1_in, s1_a2_in, s1_b1_in, s1_b2_in;

   logic signed [DET_W-1:0]  s2_pa_ff, s2_pb_ff, s2_pa_in, s2_pb_in;
   logic signed [PROD_W-1:0] s2_pn1_ff [3], s2_pn1_in [3];
   logic signed [PROD_W-1:0] s2_pn2_ff [3], s2_pn2_in [3];

   logic signed [DET_W-1:0]  s3_dd_ff, s3_dd_in;
   logic signed [N_W-1:0]    s3_n_ff [3], s3_n_in [3];

   logic [MAG_W-1:0]         s4_mag_ff, s4_mag_in;
   logic signed [N_W-1:0]    s4_n_ff [3], s4_n_in [3];
   logic                     s4_degen_ff, s4_degen_in;

   ttp_pkg::cell_data_type   s5_ff, s5_in;

   // a stage moves when it is empty or the next one moves
   always_comb begin
      take[4] = !v_ff[4] || out_ready;
      for (int i = 3; i >= 0; i--) begin
         take[i] = !v_ff[i] || take[i+1];
      end
      v_in = v_ff;
      v_in[0] = take[0] ? req_chan.valid : v_ff[0];
      for (int i = 1; i < 5; i++) begin
         if (take[i]) begin
            v_in[i] = v_ff[i-1];
         end
      end
   end

   assign req_chan.ready = take[0];
   assign out_valid      = v_ff[4];
   assign out_data       = s5_ff;

   // stage 1: deltas
   always_comb begin
      logic [UVB-1:0] u0, u1, u2, w0, w1, w2;
      u0 = req_chan.uv_word_0[UVB-1:0];
      u1 = req_chan.uv_word_1[UVB-1:0];
      u2 = req_chan.uv_word_2[UVB-1:0];
      w0 = req_chan.uv_word_0[ttp_pkg::V_LSB+UVB-1:ttp_pkg::V_LSB];
      w1 = req_chan.uv_word_1[ttp_pkg::V_LSB+UVB-1:ttp_pkg::V_LSB];
      w2 = req_chan.uv_word_2[ttp_pkg::V_LSB+UVB-1:ttp_pkg::V_LSB];
      s1_a1_in = signed'({1'b0, u1}) - signed'({1'b0, u0});
      s1_a2_in = signed'({1'b0, u2}) - signed'({1'b0, u0});
      s1_b1_in = signed'({1'b0, w1}) - signed'({1'b0, w0});
      s1_b2_in = signed'({1'b0, w2}) - signed'({1'b0, w0});
      s1_dp1_in[0] = DP_W'(req_chan.p1_x) - DP_W'(req_chan.p0_x);
      s1_dp1_in[1] = DP_W'(req_chan.p1_y) - DP_W'(req_chan.p0_y);
      s1_dp1_in[2] = DP_W'(req_chan.p1_z) - DP_W'(req_chan.p0_z);
      s1_dp2_in[0] = DP_W'(req_chan.p2_x) - DP_W'(req_chan.p0_x);
      s1_dp2_in[1] = DP_W'(req_chan.p2_y) - DP_W'(req_chan.p0_y);
      s1_dp2_in[2] = DP_W'(req_chan.p2_z) - DP_W'(req_chan.p0_z);
   end

   // stage 2: products
   always_comb begin
      s2_pa_in = DET_W'(s1_a1_ff) * DET_W'(s1_b2_ff);
      s2_pb_in = DET_W'(s1_b1_ff) * DET_W'(s1_a2_ff);
      for (int k = 0; k < 3; k++) begin
         s2_pn1_in[k] = PROD_W'(s1_dp1_ff[k]) * PROD_W'(s1_b2_ff);
         s2_pn2_in[k] = PROD_W'(s1_dp2_ff[k]) * PROD_W'(s1_b1_ff);
      end
   end

   // stage 3: determinant and numerators
   always_comb begin
      s3_dd_in = s2_pa_ff - s2_pb_ff;
      for (int k = 0; k < 3; k++) begin
         s3_n_in[k] = N_W'(s2_pn1_ff[k]) - N_W'(s2_pn2_ff[k]);
      end
   end

   // stage 4: fold the sign of d into the numerators
   always_comb begin
      logic signed [DET_W-1:0] dd_abs;
      dd_abs = s3_dd_ff[DET_W-1] ? -s3_dd_ff : s3_dd_ff;
      s4_mag_in = dd_abs[MAG_W-1:0];
      for (int k = 0; k < 3; k++) begin
         s4_n_in[k] = s3_dd_ff[DET_W-1] ? -s3_n_ff[k] : s3_n_ff[k];
      end
      s4_degen_in = (s4_mag_in <= MAG_W'(ttp_pkg::DEGEN_LIMIT));
   end

   // stage 5: m = 13107200*|d|, saturation tests and the first dividend
   always_comb begin
      logic [M_W-1:0]          m25, m;
      logic signed [S_W-1:0]   s;
      logic signed [CMP_W-1:0] sc, mc, xc;
      m25 = (M_W'(s4_mag_ff) << 4) + (M_W'(s4_mag_ff) << 3) + M_W'(s4_mag_ff);
      m   = m25 << ttp_pkg::M_SHIFT;
      mc  = signed'(CMP_W'(m));
      s5_in.den   = {m, 1'b0};
      s5_in.degen = s4_degen_ff;
      s5_in.quo   = '0;
      for (int k = 0; k < 3; k++) begin
         s  = S_W'(s4_n_ff[k]) <<< UVB;
         sc = CMP_W'(s);
         xc = sc + mc;
         s5_in.sat_hi[k] = (sc >= mc);
         s5_in.sat_lo[k] = (sc <= -mc);
         s5_in.rem[k]    = xc[DEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take[0]) begin
         s1_dp1_ff <= s1_dp1_in;
         s1_dp2_ff <= s1_dp2_in;
         s1_a1_ff  <= s1_a1_in;
         s1_a2_ff  <= s1_a2_in;
         s1_b1_ff  <= s1_b1_in;
         s1_b2_ff  <= s1_b2_in;
      end
      if (take[1]) begin
         s2_pa_ff  <= s2_pa_in;
         s2_pb_ff  <= s2_pb_in;
         s2_pn1_ff <= s2_pn1_in;
         s2_pn2_ff <= s2_pn2_in;
      end
      if (take[2]) begin
         s3_dd_ff <= s3_dd_in;
         s3_n_ff  <= s3_n_in;
      end
      if (take[3]) begin
         s4_mag_ff   <= s4_mag_in;
         s4_n_ff     <= s4_n_in;
         s4_degen_ff <= s4_degen_in;
      end
      if (take[4]) begin
         s5_ff <= s5_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/ttp_div_cell.sv =====
// ttp_div_cell: one restoring-division step, one quotient bit for each of the three components
// depends on ttp_pkg; cells are chained in the top level
`default_nettype none

module ttp_div_cell (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   input  wire ttp_pkg::cell_data_type in_data,
   output logic                        in_ready,
   output logic                        out_valid,
   output ttp_pkg::cell_data_type      out_data,
   input  wire logic                   out_ready
);

   localparam int DEN_W = ttp_pkg::DEN_W;
   localparam int FB    = ttp_pkg::FRAC_BITS;

   logic                   valid_ff, valid_in, take;
   ttp_pkg::cell_data_type data_ff, data_in;

   assign take     = !valid_ff || out_ready;
   assign in_ready = take;
   assign valid_in = take ? in_valid : valid_ff;

   always_comb begin
      logic [DEN_W:0] sh, dn;
      logic           bit_q;
      data_in = in_data;
      dn = {1'b0, in_data.den};
      for (int k = 0; k < 3; k++) begin
         sh    = {in_data.rem[k], 1'b0};
         bit_q = (sh >= dn);
         if (bit_q) begin
            sh = sh - dn;
         end
         data_in.rem[k] = sh[DEN_W-1:0];
         data_in.quo[k] = {in_data.quo[k][FB-2:0], bit_q};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ===== design/triangle_tangent_pack_unit.sv =====
// channel   direction  beat contents
// req_chan  in         three Q16.16 vertex positions, three packed uv words
// rsp_chan  out        packed 9-bit tangent codes in 10-bit fields and the degenerate flag
//
// path: five front stages, nine divider cells (one code bit each), output register
// one triangle per cycle while responses are taken; every stage is its own register with per-stage ready
// reset clears the valid bits only; payload registers carry no reset
// a stalled response holds the output; upstream bubbles still close up behind it
// depends on ttp_pkg, ttp_channels, ttp_front, ttp_div_cell
`default_nettype none

module triangle_tangent_pack_unit (
   input  wire logic clock,
   input  wire logic reset,
   ttp_req_if.sink   req_chan,
   ttp_rsp_if.source rsp_chan
);

   localparam int FB = ttp_pkg::FRAC_BITS;
   localparam int FS = ttp_pkg::FIELD_STRIDE;

   logic                   c_valid [FB+1];
   logic                   c_ready [FB+1];
   ttp_pkg::cell_data_type c_data  [FB+1];

   ttp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .out_valid (c_valid[0]),
      .out_data  (c_data[0]),
      .out_ready (c_ready[0])
   );

   for (genvar g = 0; g < FB; g++) begin : g_cell
      ttp_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (c_valid[g]),
         .in_data   (c_data[g]),
         .in_ready  (c_ready[g]),
         .out_valid (c_valid[g+1]),
         .out_data  (c_data[g+1]),
         .out_ready (c_ready[g+1])
      );
   end

   logic                       rsp_valid_ff, rsp_valid_in, take_out;
   logic [ttp_pkg::OUT_W-1:0]  word_ff, word_in;
   logic                       degen_ff;

   assign take_out        = !rsp_valid_ff || rsp_chan.ready;
   assign c_ready[FB]     = take_out;
   assign rsp_valid_in    = take_out ? c_valid[FB] : rsp_valid_ff;

   always_comb begin
      logic [FB-1:0] code [3];
      for (int k = 0; k < 3; k++) begin
         if (c_data[FB].sat_hi[k]) begin
            code[k] = FB'(ttp_pkg::CODE_MAX);
         end else if (c_data[FB].sat_lo[k]) begin
            code[k] = '0;
         end else begin
            code[k] = c_data[FB].quo[k];
         end
      end
      if (c_data[FB].degen) begin
         word_in = ttp_pkg::DEFAULT_WORD;
      end else begin
         word_in = {FS'(code[2]), FS'(code[1]), FS'(code[0])};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_out) begin
         word_ff  <= word_in;
         degen_ff <= c_data[FB].degen;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.tangent_word = word_ff;
   assign rsp_chan.degenerate   = degen_ff;

   a_degen_word: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.degenerate |-> rsp_chan.tangent_word == ttp_pkg::DEFAULT_WORD)
      else $error("degenerate beat without default tangent");

   a_empty_out_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_chan.ready)
      else $error("input stalled with empty output register");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_chan.valid)
      else $error("response valid right after reset");

   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |->
         rsp_chan.tangent_word[FS-1:0] <= FS'(ttp_pkg::CODE_MAX) &&
         rsp_chan.tangent_word[2*FS-1:FS] <= FS'(ttp_pkg::CODE_MAX) &&
         rsp_chan.tangent_word[3*FS-1:2*FS] <= FS'(ttp_pkg::CODE_MAX))
      else $error("tangent code above top code");

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// tb: self-checking bench for triangle_tangent_pack_unit, directed and random triangles against an exact predictor
// depends on ttp_pkg, ttp_channels and the unit itself
`default_nettype none

module tb;

   typedef struct {
      logic signed [ttp_pkg::POS_W-1:0] p [3][3];
      logic [ttp_pkg::UV_W-1:0]         uv [3];
   } tri_type;

   typedef struct {
      logic [ttp_pkg::OUT_W-1:0] word;
      logic                      degen;
   } tan_type;

   // floor(num/den * 2^frac) saturated, den > 0
   function automatic int unsigned frac_bits_of(longint num, longint den);
      longint r;
      int unsigned q;
      q = 0;
      if (num <= 0) return 0;
      if (num >= den) return ttp_pkg::CODE_MAX;
      r = num;
      for (int i = 0; i < ttp_pkg::FRAC_BITS; i++) begin
         r = r <<< 1;
         q = q << 1;
         if (r >= den) begin
            r = r - den;
            q = q | 1;
         end
      end
      return q;
   endfunction

   function automatic int unsigned axis_code(longint n, longint d);
      longint m, lim;
      m = 64'sd13107200 * d;
      lim = (m + ((64'sd1 <<< ttp_pkg::UV_CODE_BITS) - 1)) / (64'sd1 <<< ttp_pkg::UV_CODE_BITS);
      if (n >= lim) return ttp_pkg::CODE_MAX;
      if (n <= -lim) return 0;
      return frac_bits_of(n * (64'sd1 <<< ttp_pkg::UV_CODE_BITS) + m, 2 * m);
   endfunction

   function automatic tan_type tangent_of(tri_type t);
      longint u [3], v [3];
      longint a1, a2, b1, b2, det, adet, n, dp1, dp2;
      int unsigned c [3];
      tan_type r;
      for (int i = 0; i < 3; i++) begin
         u[i] = t.uv[i] & ((1 << ttp_pkg::UV_CODE_BITS) - 1);
         v[i] = (t.uv[i] >> ttp_pkg::V_LSB) & ((1 << ttp_pkg::UV_CODE_BITS) - 1);
      end
      a1 = u[1] - u[0];
      a2 = u[2] - u[0];
      b1 = v[1] - v[0];
      b2 = v[2] - v[0];
      det = a1 * b2 - b1 * a2;
      adet = det < 0 ? -det : det;
      r.degen = !(adet * 64'sd400000000 > (64'sd1 <<< (2 * ttp_pkg::UV_CODE_BITS)));
      if (r.degen) begin
         c[0] = frac_bits_of(10, 20);
         c[1] = frac_bits_of(10, 20);
         c[2] = frac_bits_of(11, 20);
      end else begin
         for (int k = 0; k < 3; k++) begin
            dp1 = longint'(t.p[1][k]) - longint'(t.p[0][k]);
            dp2 = longint'(t.p[2][k]) - longint'(t.p[0][k]);
            n = dp1 * b2 - dp2 * b1;
            c[k] = det < 0 ? axis_code(-n, -det) : axis_code(n, det);
         end
      end
      r.word = ttp_pkg::OUT_W'(c[0] | (c[1] << 10) | (c[2] << 20));
      return r;
   endfunction

   class tangent_board;
      tan_type pending [$];
      int errors = 0;
      int checked = 0;
      int degens = 0;

      function void note_triangle(tri_type t);
         pending.insert(pending.size(), tangent_of(t));
      endfunction

      function void check_tangent(logic [ttp_pkg::OUT_W-1:0] word, logic degen);
         tan_type e;
         checked++;
         if (pending.size() == 0) begin
            $display("%0t: unexpected beat word=%h degen=%b", $time, word, degen);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (degen) degens++;
         if (word !== e.word) begin
            $display("%0t: tangent_word expected %h actual %h", $time, e.word, word);
            errors++;
         end
         if (degen !== e.degen) begin
            $display("%0t: degenerate expected %b actual %b", $time, e.degen, degen);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   ttp_req_if req_chan ();
   ttp_rsp_if rsp_chan ();
   tangent_board board = new();

   int send_idle = 0;
   int recv_idle = 0;
   bit hold_rsp = 0;
   int quiet = 0;
   bit stim_done = 0;
   bit req_fire = 0;
   localparam int WATCHDOG = 5000;

   triangle_tangent_pack_unit dut (.clock(clock), .reset(reset),
      .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source));

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   // sample at the rising edge
   always @(posedge clock) begin
      req_fire <= req_chan.valid && req_chan.ready;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            tri_type t;
            t.p[0][0] = req_chan.p0_x; t.p[0][1] = req_chan.p0_y; t.p[0][2] = req_chan.p0_z;
            t.p[1][0] = req_chan.p1_x; t.p[1][1] = req_chan.p1_y; t.p[1][2] = req_chan.p1_z;
            t.p[2][0] = req_chan.p2_x; t.p[2][1] = req_chan.p2_y; t.p[2][2] = req_chan.p2_z;
            t.uv[0] = req_chan.uv_word_0; t.uv[1] = req_chan.uv_word_1;
            t.uv[2] = req_chan.uv_word_2;
            board.note_triangle(t);
         end
         if (rsp_chan.valid && rsp_chan.ready)
            board.check_tangent(rsp_chan.tangent_word, rsp_chan.degenerate);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
             || (stim_done && board.pending.size() == 0))
            quiet <= 0;
         else
            quiet <= quiet + 1;
      end
   end

   always @(posedge clock) begin
      if (quiet >= WATCHDOG) begin
         $display("watchdog: no progress for %0d cycles", WATCHDOG);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // receiver side
   always @(negedge clock) begin
      if (reset || hold_rsp)
         rsp_chan.ready <= 1'b0;
      else
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle);
   end

   function automatic logic [ttp_pkg::UV_W-1:0] rand_uv();
      logic [31:0] w;
      w = $urandom();
      // mostly clean codes, sometimes stray bits above the fields
      if ($urandom_range(3) != 0) w = w & 32'h3fff3fff;
      return w[ttp_pkg::UV_W-1:0];
   endfunction

   function automatic logic signed [ttp_pkg::POS_W-1:0] rand_pos();
      case ($urandom_range(3))
         0: return $urandom();
         1: return $signed($urandom_range(65536 * 8)) - 32'sd262144;
         2: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
         default: return $signed(32'($urandom_range(2000))) - 32'sd1000;
      endcase
   endfunction

   function automatic tri_type rand_tri();
      tri_type t;
      logic [13:0] u0, v0;
      for (int i = 0; i < 3; i++)
         for (int k = 0; k < 3; k++)
            t.p[i][k] = rand_pos();
      case ($urandom_range(5))
         0: begin
            // near-degenerate: small uv spread
            u0 = 14'($urandom()); v0 = 14'($urandom());
            for (int i = 0; i < 3; i++)
               t.uv[i] = {2'b0, 14'(v0 + $urandom_range(2)), 2'b0, 14'(u0 + $urandom_range(2))};
         end
         1: begin
            // collinear uvs
            u0 = 14'($urandom_range(4000)); v0 = 14'($urandom_range(4000));
            t.uv[0] = {2'b0, v0, 2'b0, u0};
            t.uv[1] = {2'b0, 14'(v0 + 100), 2'b0, 14'(u0 + 200)};
            t.uv[2] = {2'b0, 14'(v0 + 300), 2'b0, 14'(u0 + 600)};
         end
         default: for (int i = 0; i < 3; i++) t.uv[i] = rand_uv();
      endcase
      return t;
   endfunction

   // valid stays up after the beat so the next call can follow without a gap
   task automatic send_tri(tri_type t);
      while (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.p0_x <= t.p[0][0]; req_chan.p0_y <= t.p[0][1]; req_chan.p0_z <= t.p[0][2];
      req_chan.p1_x <= t.p[1][0]; req_chan.p1_y <= t.p[1][1]; req_chan.p1_z <= t.p[1][2];
      req_chan.p2_x <= t.p[2][0]; req_chan.p2_y <= t.p[2][1]; req_chan.p2_z <= t.p[2][2];
      req_chan.uv_word_0 <= t.uv[0];
      req_chan.uv_word_1 <= t.uv[1];
      req_chan.uv_word_2 <= t.uv[2];
      // req_fire holds the handshake seen at the last rising edge
      @(negedge clock);
      while (!req_fire) @(negedge clock);
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      while (board.pending.size() != 0) @(negedge clock);
   endtask

   function automatic tri_type flat_tri(logic signed [ttp_pkg::POS_W-1:0] pv,
                                        logic [ttp_pkg::UV_W-1:0] uv0,
                                        logic [ttp_pkg::UV_W-1:0] uv1,
                                        logic [ttp_pkg::UV_W-1:0] uv2);
      tri_type t;
      for (int i = 0; i < 3; i++)
         for (int k = 0; k < 3; k++)
            t.p[i][k] = pv;
      t.uv[0] = uv0; t.uv[1] = uv1; t.uv[2] = uv2;
      return t;
   endfunction

   initial begin
      tri_type t;
      req_chan.valid = 0;
      req_chan.p0_x = 0; req_chan.p0_y = 0; req_chan.p0_z = 0;
      req_chan.p1_x = 0; req_chan.p1_y = 0; req_chan.p1_z = 0;
      req_chan.p2_x = 0; req_chan.p2_y = 0; req_chan.p2_z = 0;
      req_chan.uv_word_0 = 0; req_chan.uv_word_1 = 0; req_chan.uv_word_2 = 0;
      rsp_chan.ready = 0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // directed: degenerate, unit uv triangle, extremes, stray bits
      send_tri(flat_tri(0, 0, 0, 0));
      send_tri(flat_tri(32'sh7fffffff, 30'h3fff3fff, 30'h3fff3fff, 30'h3fff3fff));
      t = flat_tri(0, 30'h0, 30'h3fff, 30'h3fff0000);
      t.p[1][0] = 32'sh00010000; t.p[2][1] = 32'sh00010000; t.p[1][2] = -32'sh00010000;
      send_tri(t);
      t.p[1][0] = 32'sh7fffffff; t.p[2][0] = 32'sh80000000;
      t.p[1][1] = 32'sh80000000; t.p[2][1] = 32'sh7fffffff;
      send_tri(t);
      t.uv[1] = 30'h3fff; t.uv[2] = 30'h1;
      send_tri(t);
      send_tri(flat_tri(32'sh80000000, 30'h3fffffff, 30'h0000c000, 30'h3fffffff));
      t = flat_tri(0, 30'h0, 30'h00000001, 30'h00010000);
      t.p[1][0] = 32'sh00000001; t.p[2][2] = 32'shffffffff;
      send_tri(t);
      t.uv[0] = 30'h3fff3fff; t.uv[1] = 30'h3fff0000; t.uv[2] = 30'h00003fff;
      send_tri(t);
      t = flat_tri(0, 30'h00000000, 30'h00000000, 30'h00000000);
      t.uv[0] = 30'h30000000; t.uv[1] = 30'h0000c000;
      send_tri(t);
      for (int i = 0; i < 12; i++) send_tri(rand_tri());
      drain();

      // receiver stalls for a long stretch while triangles keep coming
      hold_rsp = 1;
      fork
         begin
            for (int i = 0; i < 40; i++) send_tri(rand_tri());
         end
         begin
            repeat (200) @(negedge clock);
            hold_rsp = 0;
         end
      join
      drain();

      send_idle = 25; recv_idle = 84;
      for (int i = 0; i < 600; i++) send_tri(rand_tri());
      drain();
      send_idle = 84; recv_idle = 25;
      for (int i = 0; i < 600; i++) send_tri(rand_tri());
      send_idle = 0; recv_idle = 0;
      for (int i = 0; i < 600; i++) send_tri(rand_tri());

      stim_done = 1;
      drain();
      repeat (30) @(negedge clock);
      $display("checked %0d tangents (%0d degenerate) across stall, idle and full-rate phases",
               board.checked, board.degens);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
design/ttp_pkg.sv
design/ttp_channels.sv
design/ttp_front.sv
design/ttp_div_cell.sv
design/triangle_tangent_pack_unit.sv
sim/tb.sv
